FILE: hw/rtl/thwbd_pkg.sv
// Shared constants and controller/datapath interface types for the burst detector.
package thwbd_pkg;

    // Default widths of the window state.
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed widths of the port fields.
    localparam int EVENT_TIME_BITS = 32;
    localparam int PERIOD_BITS     = 32;
    localparam int THRESHOLD_BITS  = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_PERIOD   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BURST_THRESHOLD = 2'd1;

    // Item kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an accepted input beat
        logic step;      // advance the window bound by one period and compare
        logic div_step;  // one bit of the remainder computation
        logic update;    // commit the window state and load the result
    } thwbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gt_now;    // timestamp lies past the bound being formed this cycle
    } thwbd_status_t;

endpackage

FILE: hw/rtl/thwbd_datapath.sv
// Datapath: configuration registers, window state, bound compare and remainder unit.
module thwbd_datapath
    import thwbd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       s_kind,
    input  logic [EVENT_TIME_BITS-1:0] s_event_time,
    input  thwbd_cmd_t                 cmd,
    output thwbd_status_t              status,
    output logic                       m_burst
);

    localparam int AW = TIME_BITS + 2;
    localparam int SW = (COUNT_BITS + 1 > THRESHOLD_BITS) ? COUNT_BITS + 1 : THRESHOLD_BITS;

    logic [PERIOD_BITS-1:0]    period_reg;
    logic [THRESHOLD_BITS-1:0] threshold_reg;

    logic [TIME_BITS-1:0]  base_reg;
    logic [COUNT_BITS-1:0] first_reg;
    logic [COUNT_BITS-1:0] second_reg;

    logic                  kind_reg;
    logic [TIME_BITS-1:0]  t_reg;
    logic [TIME_BITS-1:0]  p_reg;
    logic [AW-1:0]         acc_reg;
    logic [2:0]            flags_reg;
    logic [TIME_BITS-1:0]  dq_reg;
    logic [TIME_BITS-1:0]  rem_reg;
    logic                  burst_reg;

    logic [TIME_BITS-1:0]  t_in;
    logic [TIME_BITS-1:0]  p_in;
    logic [TIME_BITS-1:0]  p_eff;
    logic [AW-1:0]         acc_sum;
    logic [TIME_BITS:0]    rem_sh;
    logic [TIME_BITS:0]    rem_sub;
    logic [TIME_BITS-1:0]  base_next;
    logic [COUNT_BITS-1:0] first_next;
    logic [COUNT_BITS-1:0] second_next;
    logic [COUNT_BITS-1:0] first_inc;
    logic [COUNT_BITS-1:0] second_inc;
    logic [COUNT_BITS:0]   count_sum;
    logic                  burst_next;

    // Configuration registers; the port never stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_BITS'(1);
            threshold_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_WINDOW_PERIOD) begin
                period_reg <= cfg_data;
            end else if (cfg_index == REG_BURST_THRESHOLD) begin
                threshold_reg <= cfg_data[THRESHOLD_BITS-1:0];
            end
        end
    end

    // Input timestamp and period at the state width; a zero period acts as one.
    assign t_in  = TIME_BITS'(s_event_time);
    assign p_in  = TIME_BITS'(period_reg);
    assign p_eff = (p_in == '0) ? TIME_BITS'(1) : p_in;

    // Window bound base + k * period, formed wide so it never wraps.
    assign acc_sum       = acc_reg + AW'(p_reg);
    assign status.gt_now = (AW'(t_reg) > acc_sum);

    // One restoring step of the remainder of the timestamp by the period.
    assign rem_sh  = {rem_reg, dq_reg[TIME_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, p_reg};

    // Saturating increments of the two half counts.
    assign first_inc  = (first_reg == '1) ? first_reg : first_reg + COUNT_BITS'(1);
    assign second_inc = (second_reg == '1) ? second_reg : second_reg + COUNT_BITS'(1);

    // Next window state. The compare flags hold, from oldest to newest,
    // past one, two and three periods after the base.
    always_comb begin
        base_next   = base_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (kind_reg == KIND_CLEAR) begin
            base_next   = '0;
            first_next  = '0;
            second_next = '0;
        end else if (flags_reg[0]) begin
            // Restart: base floored to a multiple of the period.
            base_next   = t_reg - rem_reg;
            first_next  = COUNT_BITS'(1);
            second_next = '0;
        end else if (flags_reg[1]) begin
            // Slide by one period.
            base_next   = base_reg + p_reg;
            first_next  = second_reg;
            second_next = COUNT_BITS'(1);
        end else if (flags_reg[2]) begin
            second_next = second_inc;
        end else begin
            first_next = first_inc;
        end
    end

    assign count_sum  = {1'b0, first_next} + {1'b0, second_next};
    assign burst_next = (kind_reg == KIND_RECORD) && (SW'(count_sum) > SW'(threshold_reg));

    // Window state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (cmd.update) begin
            base_reg   <= base_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_kind;
            t_reg     <= t_in;
            p_reg     <= p_eff;
            acc_reg   <= AW'(base_reg);
            flags_reg <= '0;
            dq_reg    <= t_in;
            rem_reg   <= '0;
        end else begin
            if (cmd.step) begin
                acc_reg   <= acc_sum;
                flags_reg <= {flags_reg[1:0], status.gt_now};
            end
            if (cmd.div_step) begin
                dq_reg <= dq_reg << 1;
                if (!rem_sub[TIME_BITS]) begin
                    rem_reg <= rem_sub[TIME_BITS-1:0];
                end else begin
                    rem_reg <= rem_sh[TIME_BITS-1:0];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            burst_reg <= burst_next;
        end
    end

    assign m_burst = burst_reg;

endmodule

FILE: hw/rtl/thwbd_controller.sv
// Controller: sequences the compare steps, the remainder loop and the result handshake.
module thwbd_controller
    import thwbd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_kind,
    output logic          m_valid,
    input  logic          m_ready,
    input  thwbd_status_t status,
    output thwbd_cmd_t    cmd
);

    localparam int CW = $clog2(TIME_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP1 = 3'd1;
    localparam logic [2:0] ST_CMP2 = 3'd2;
    localparam logic [2:0] ST_CMP3 = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          m_valid_reg;
    logic          m_valid_next;

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_kind == KIND_CLEAR) ? ST_UPD : ST_CMP1;
                end
            end
            ST_CMP1: begin
                cmd.step   = 1'b1;
                state_next = ST_CMP2;
            end
            ST_CMP2: begin
                cmd.step   = 1'b1;
                state_next = ST_CMP3;
            end
            ST_CMP3: begin
                // Past three periods: the new base needs the remainder.
                cmd.step   = 1'b1;
                cnt_next   = '0;
                state_next = status.gt_now ? ST_DIV : ST_UPD;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(TIME_BITS - 1)) begin
                    state_next = ST_UPD;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_UPD: begin
                // Commit only once the result register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.update   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: hw/rtl/two_half_window_burst_detector_core.sv
// Record beat to result: CMP1, CMP2, CMP3 and UPD, with DIV before UPD on a restart.
// The restart path runs a bit-serial remainder of the timestamp by the period.
// Clear beat to result: UPD only, which waits for a free result register.
// One item is in flight; the next beat is taken once the result is loaded.
// Synchronous active-low reset clears the window, sets period 1 and threshold 0.
// Top level: burst detector over a two-half sliding window.
module two_half_window_burst_detector_core
    import thwbd_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [EVENT_TIME_BITS-1:0] s_event_time,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_burst
);

    thwbd_cmd_t    cmd;
    thwbd_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    thwbd_controller #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    thwbd_datapath #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_kind       (s_kind),
        .s_event_time (s_event_time),
        .cmd          (cmd),
        .status       (status),
        .m_burst      (m_burst)
    );

endmodule

FILE: hw/rtl/thwbd_checker.sv
// Port-level checker for the burst detector, bound to the top level.
module thwbd_checker
    import thwbd_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input logic [CFG_DATA_BITS-1:0]   cfg_data,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_kind,
    input logic [EVENT_TIME_BITS-1:0] s_event_time,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_burst
);

    // A result beat that is held back keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_burst)))
        else $error("result beat changed while stalled");

    // Only one item is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    // A clear item with the result side empty gives a non-burst result without a stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == KIND_CLEAR) && !m_valid)
            |-> ##2 (m_valid && !m_burst))
        else $error("clear item did not give a zero result in time");

    // Reset empties the result side.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind two_half_window_burst_detector_core thwbd_checker u_thwbd_checker (.*);
